### sv/pipft_pkg.sv
// Shared types for the point-in-polygon fan test unit.
// Holds the per-vertex flag struct passed from front end to back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pipft_pkg;

	// Per-vertex control flags, worked out by the front end
	typedef struct packed {
		logic start;   // first vertex of a polygon: clear the hit accumulator
		logic eval;    // vertex closes a fan triangle
		logic last;    // final vertex: emit a result
		logic few;     // polygon ends with fewer than three vertices
		logic degen;   // first, previous and current vertex coincide
		logic pt_eq;   // query point equals the first vertex
	} pipft_flags_t;

	localparam int unsigned FLAG_W = $bits(pipft_flags_t);

	// Slot order of coordinates in a packed job word
	localparam int unsigned SLOT_QX = 0;
	localparam int unsigned SLOT_QY = 1;
	localparam int unsigned SLOT_FX = 2;
	localparam int unsigned SLOT_FY = 3;
	localparam int unsigned SLOT_PX = 4;
	localparam int unsigned SLOT_PY = 5;
	localparam int unsigned SLOT_VX = 6;
	localparam int unsigned SLOT_VY = 7;
	localparam int unsigned NUM_SLOTS = 8;

	// Input command codes
	localparam logic CMD_POINT  = 1'b0;
	localparam logic CMD_VERTEX = 1'b1;

endpackage

`default_nettype wire

### sv/pipft_front.sv
// Front end: accepts point and vertex beats, tracks query, first and previous vertex.
// Emits one job per vertex beat with its triangle and flags. Depends on pipft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pipft_front import pipft_pkg::*; #(
	parameter int unsigned COORD_BITS   = 24,
	parameter int unsigned MAX_VERTICES = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output      logic                             in_ready,
	input  wire logic                             command,
	input  wire logic signed [COORD_BITS-1:0]     x_coord,
	input  wire logic signed [COORD_BITS-1:0]     y_coord,
	input  wire logic                             last_vertex,
	output      logic                             job_valid,
	input  wire logic                             job_ready,
	output      pipft_flags_t                     job_flags,
	output      logic [NUM_SLOTS*COORD_BITS-1:0]  job_coords
);

	localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

	logic signed [COORD_BITS-1:0] query_x_q, query_y_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_inc;
	logic                         accept;
	logic                         is_vertex;
	logic                         count_zero;

	// Hold off only when the queue is full
	assign in_ready   = job_ready;
	assign accept     = in_valid && in_ready;
	assign is_vertex  = (command == CMD_VERTEX);
	assign count_zero = (count_q == '0);

	// Saturating count after this vertex
	assign count_inc = (count_q < CNT_W'(MAX_VERTICES)) ? count_q + CNT_W'(1) : count_q;

	// Build the job for the current vertex beat
	assign job_valid        = in_valid && is_vertex;
	assign job_flags.start  = count_zero;
	assign job_flags.eval   = (count_q >= CNT_W'(2));
	assign job_flags.last   = last_vertex;
	assign job_flags.few    = (count_inc < CNT_W'(3));
	assign job_flags.degen  = (first_x_q == prev_x_q) && (first_y_q == prev_y_q) &&
	                          (prev_x_q == x_coord) && (prev_y_q == y_coord);
	assign job_flags.pt_eq  = (query_x_q == first_x_q) && (query_y_q == first_y_q);

	assign job_coords[SLOT_QX*COORD_BITS +: COORD_BITS] = query_x_q;
	assign job_coords[SLOT_QY*COORD_BITS +: COORD_BITS] = query_y_q;
	assign job_coords[SLOT_FX*COORD_BITS +: COORD_BITS] = count_zero ? x_coord : first_x_q;
	assign job_coords[SLOT_FY*COORD_BITS +: COORD_BITS] = count_zero ? y_coord : first_y_q;
	assign job_coords[SLOT_PX*COORD_BITS +: COORD_BITS] = prev_x_q;
	assign job_coords[SLOT_PY*COORD_BITS +: COORD_BITS] = prev_y_q;
	assign job_coords[SLOT_VX*COORD_BITS +: COORD_BITS] = x_coord;
	assign job_coords[SLOT_VY*COORD_BITS +: COORD_BITS] = y_coord;

	// Update the polygon state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (!is_vertex) begin
				query_x_q <= x_coord;
				query_y_q <= y_coord;
				count_q   <= '0;
			end else begin
				if (count_zero) begin
					first_x_q <= x_coord;
					first_y_q <= y_coord;
				end
				prev_x_q <= x_coord;
				prev_y_q <= y_coord;
				count_q  <= last_vertex ? '0 : count_inc;
			end
		end
	end

	// Count never passes its ceiling
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("pipft_front: vertex count beyond ceiling");

endmodule

`default_nettype wire

### sv/pipft_fifo.sv
// Short register queue between front end and back end.
// Generic width; depth a power of two. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pipft_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output      logic             push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             pop_valid,
	input  wire logic             pop_ready,
	output      logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Occupancy stays within depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("pipft_fifo: occupancy beyond depth");

endmodule

`default_nettype wire

### sv/pipft_back.sv
// Back end: evaluates fan triangles in a three-stage pipeline and emits results.
// Edge differences, exact products, then sign tests and hit accumulation. Depends on pipft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pipft_back import pipft_pkg::*; #(
	parameter int unsigned COORD_BITS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             job_valid,
	output      logic                             job_ready,
	input  wire pipft_flags_t                     job_flags,
	input  wire logic [NUM_SLOTS*COORD_BITS-1:0]  job_coords,
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic                             inside_res,
	output      logic                             too_few_vertices
);

	localparam int unsigned D_W = COORD_BITS + 1;
	localparam int unsigned P_W = 2 * D_W;
	localparam int unsigned C_W = P_W + 1;

	function automatic logic signed [D_W-1:0] diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [D_W-1:0] ea, eb;
		ea = D_W'(a);
		eb = D_W'(b);
		return ea - eb;
	endfunction

	logic signed [COORD_BITS-1:0] qx, qy, ax [3], ay [3], bx [3], by [3];

	// Stage 1: edge differences for the three cross products
	logic                  valid_s1;
	pipft_flags_t          flags_s1;
	logic signed [D_W-1:0] dxp_s1 [3], dyb_s1 [3], dxb_s1 [3], dyp_s1 [3];

	// Stage 2: exact products
	logic                  valid_s2;
	pipft_flags_t          flags_s2;
	logic signed [P_W-1:0] pa_s2 [3], pb_s2 [3];

	logic                  out_valid_q, inside_q, few_q, hit_acc_q;
	logic                  stall, adv;
	logic [2:0]            nonpos;
	logic signed [C_W-1:0] xprod [3];
	logic                  tri_hit, acc_next;

	assign qx = job_coords[SLOT_QX*COORD_BITS +: COORD_BITS];
	assign qy = job_coords[SLOT_QY*COORD_BITS +: COORD_BITS];

	// Edges: (prev, first), (current, prev), (first, current)
	assign ax[0] = job_coords[SLOT_PX*COORD_BITS +: COORD_BITS];
	assign ay[0] = job_coords[SLOT_PY*COORD_BITS +: COORD_BITS];
	assign bx[0] = job_coords[SLOT_FX*COORD_BITS +: COORD_BITS];
	assign by[0] = job_coords[SLOT_FY*COORD_BITS +: COORD_BITS];
	assign ax[1] = job_coords[SLOT_VX*COORD_BITS +: COORD_BITS];
	assign ay[1] = job_coords[SLOT_VY*COORD_BITS +: COORD_BITS];
	assign bx[1] = job_coords[SLOT_PX*COORD_BITS +: COORD_BITS];
	assign by[1] = job_coords[SLOT_PY*COORD_BITS +: COORD_BITS];
	assign ax[2] = job_coords[SLOT_FX*COORD_BITS +: COORD_BITS];
	assign ay[2] = job_coords[SLOT_FY*COORD_BITS +: COORD_BITS];
	assign bx[2] = job_coords[SLOT_VX*COORD_BITS +: COORD_BITS];
	assign by[2] = job_coords[SLOT_VY*COORD_BITS +: COORD_BITS];

	// Freeze the pipe only when a result cannot leave
	assign stall     = valid_s2 && flags_s2.last && out_valid_q && !out_ready;
	assign adv       = !stall;
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= job_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1 <= job_flags;
			flags_s2 <= flags_s1;
			for (int k = 0; k < 3; k++) begin
				dxp_s1[k] <= diff(qx, ax[k]);
				dyb_s1[k] <= diff(by[k], ay[k]);
				dxb_s1[k] <= diff(bx[k], ax[k]);
				dyp_s1[k] <= diff(qy, ay[k]);
				pa_s2[k]  <= dxp_s1[k] * dyb_s1[k];
				pb_s2[k]  <= dxb_s1[k] * dyp_s1[k];
			end
		end
	end

	// Stage 3: sign tests, triangle hit and accumulation
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			xprod[k]  = C_W'(pa_s2[k]) - C_W'(pb_s2[k]);
			nonpos[k] = xprod[k][C_W-1] || (xprod[k] == '0);
		end
		if (flags_s2.degen) begin
			tri_hit = flags_s2.pt_eq;
		end else begin
			tri_hit = (nonpos[0] == nonpos[1]) && (nonpos[1] == nonpos[2]);
		end
		acc_next = (hit_acc_q && !flags_s2.start) || (flags_s2.eval && tri_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_acc_q   <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
			few_q       <= 1'b0;
		end else begin
			if (valid_s2 && adv && flags_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s2 && adv) begin
				hit_acc_q <= flags_s2.last ? 1'b0 : acc_next;
				if (flags_s2.last) begin
					inside_q    <= acc_next && !flags_s2.few;
					few_q       <= flags_s2.few;
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign inside_res       = inside_q;
	assign too_few_vertices = few_q;

	// A short polygon never reports a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && few_q) |-> !inside_q)
		else $error("pipft_back: hit reported for short polygon");

	// A closing vertex leaving stage 2 always yields a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && flags_s2.last && adv) |=> out_valid_q)
		else $error("pipft_back: result lost");

endmodule

`default_nettype wire

### sv/point_in_polygon_fan_test_unit.sv
// Point-in-polygon fan test unit.
// Input channel (in_valid/in_ready) carries command, x_coord, y_coord and
// last_vertex. A point beat (command 0) sets the query point and starts a
// new test; vertex beats (command 1) follow in order, the final one marked
// by last_vertex. Each vertex from the third onward closes a fan triangle
// with the first and previous vertex.
// Output channel (out_valid/out_ready) carries one beat per marked vertex:
// inside_res, and too_few_vertices for polygons of under three vertices.
// Throughput: one beat per cycle unless the receiver stalls; every cross product has its own
// multipliers in a three-stage pipeline behind a four-entry queue.
// The marked vertex beat passes the queue, the stage 1 and stage 2 registers and the output register.
// When the receiver stalls, vertex beats keep flowing until a second
// result backs up; then the queue fills and in_ready drops.
// Reset clears the query point, the polygon state and any pending result.
// Depends on pipft_pkg, pipft_front, pipft_fifo and pipft_back.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_fan_test_unit import pipft_pkg::*; #(
	parameter int unsigned COORD_BITS   = 24,
	parameter int unsigned MAX_VERTICES = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic                         command,
	input  wire logic signed [COORD_BITS-1:0] x_coord,
	input  wire logic signed [COORD_BITS-1:0] y_coord,
	input  wire logic                         last_vertex,
	output      logic                         out_valid,
	input  wire logic                         out_ready,
	output      logic                         inside_res,
	output      logic                         too_few_vertices
);

	localparam int unsigned COORDS_W = NUM_SLOTS * COORD_BITS;
	localparam int unsigned JOB_W    = FLAG_W + COORDS_W;

	logic                front_valid, front_ready;
	pipft_flags_t        front_flags;
	logic [COORDS_W-1:0] front_coords;
	logic                back_valid, back_ready;
	logic [JOB_W-1:0]    back_job;

	pipft_front #(
		.COORD_BITS   (COORD_BITS),
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.last_vertex (last_vertex),
		.job_valid   (front_valid),
		.job_ready   (front_ready),
		.job_flags   (front_flags),
		.job_coords  (front_coords)
	);

	pipft_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (4)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  ({front_flags, front_coords}),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_job)
	);

	pipft_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job_valid        (back_valid),
		.job_ready        (back_ready),
		.job_flags        (pipft_flags_t'(back_job[JOB_W-1 -: FLAG_W])),
		.job_coords       (back_job[COORDS_W-1:0]),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.inside_res       (inside_res),
		.too_few_vertices (too_few_vertices)
	);

endmodule

`default_nettype wire
